### rtl/hmreq_pkg.sv
package hmreq_pkg;

	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W = $clog2(QUEUE_DEPTH);

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [2:0] {
		BTN_NONE        = 3'd0,
		BTN_LEFT        = 3'd1,
		BTN_RIGHT       = 3'd2,
		BTN_MIDDLE      = 3'd3,
		BTN_SCROLL_UP   = 3'd4,
		BTN_SCROLL_DOWN = 3'd5
	} button_t;

	typedef enum logic [1:0] {
		ST_MOVE = 2'd0,
		ST_DOWN = 2'd1,
		ST_UP   = 2'd2
	} evstate_t;

	localparam logic       MODE_REPORT = 1'b0;
	localparam logic       MODE_READ   = 1'b1;
	localparam logic [7:0] BUTTON_MASK  = 8'h07;
	localparam logic [7:0] DISCARD_MASK = 8'hC0;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic [2:0] button;
		logic [1:0] state;
	} event_t;

	function automatic idx_t ring_next(idx_t i);
		return (i == idx_t'(QUEUE_DEPTH - 1)) ? '0 : idx_t'(i + 1'b1);
	endfunction

endpackage

### rtl/hmreq_if.sv
interface hmreq_req_if;
	logic       valid;
	logic       ready;
	logic       mode;
	logic [7:0] status_byte;
	logic [7:0] move_x_byte;
	logic [7:0] move_y_byte;
	logic [7:0] wheel_byte;

	modport source (output valid, mode, status_byte, move_x_byte, move_y_byte, wheel_byte,
		input ready);
	modport sink (input valid, mode, status_byte, move_x_byte, move_y_byte, wheel_byte,
		output ready);
endinterface

interface hmreq_rsp_if;
	logic              valid;
	logic              ready;
	logic              event_valid;
	logic signed [7:0] event_x;
	logic signed [7:0] event_y;
	logic        [2:0] event_button;
	logic        [1:0] event_state;

	modport source (output valid, event_valid, event_x, event_y, event_button, event_state,
		input ready);
	modport sink (input valid, event_valid, event_x, event_y, event_button, event_state,
		output ready);
endinterface

### rtl/hid_mouse_report_event_queue.sv
// Report transaction: queues a scroll event, a second event or both unless discarded; both go via S_PUSH2.
// Read transaction: when the queue is empty, the empty response is registered at acceptance;
// otherwise the event memory entry is read into a register at acceptance and sent on from the S_READ state.
// One request is in flight at a time; a request is taken only in the idle state while the response slot is free.
// Asynchronous active-low reset clears the FSM state, the buttons, both ring indexes and the response valid flag;
// the event memory is not cleared, since only written entries are ever read.
module hid_mouse_report_event_queue (
	input  logic        clk,
	input  logic        arst_n,
	hmreq_req_if.sink   req,
	hmreq_rsp_if.source rsp
);
	import hmreq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_PUSH2 = 3'b010,
		S_READ  = 3'b100
	} fsm_t;

	fsm_t       state_q;
	logic [2:0] last_buttons_q;
	idx_t       wr_idx_q;
	idx_t       rd_idx_q;
	event_t     second_q;
	event_t     rd_data_q;
	event_t     rsp_q;
	logic       rsp_valid_q;
	logic       rsp_event_valid_q;

	event_t     mem [QUEUE_DEPTH];

	logic       accept;
	logic       rsp_free;
	logic       rsp_set;
	logic       is_read;
	logic [2:0] buttons;
	logic [2:0] changed;
	logic [2:0] mask;
	logic [2:0] btn_code;
	logic       discard;
	logic       has_scroll;
	logic       has_second;
	event_t     scroll_ev;
	event_t     second_ev;
	logic       mem_we;
	event_t     mem_wdata;
	idx_t       wr_next;

	assign rsp_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && rsp_free;
	assign accept = req.valid && req.ready;
	assign is_read = (req.mode == MODE_READ);
	assign rsp_set = (state_q == S_READ) || (accept && is_read && (rd_idx_q == wr_idx_q));

	assign buttons = req.status_byte[2:0] & BUTTON_MASK[2:0];
	assign changed = buttons ^ last_buttons_q;
	assign discard = (req.status_byte & DISCARD_MASK) != 8'h00;
	assign has_scroll = (req.wheel_byte != 8'h00);

	always_comb begin
		mask = 3'b000;
		btn_code = BTN_NONE;
		if (changed[0]) begin
			mask = 3'b001;
			btn_code = BTN_LEFT;
		end else if (changed[1]) begin
			mask = 3'b010;
			btn_code = BTN_RIGHT;
		end else if (changed[2]) begin
			mask = 3'b100;
			btn_code = BTN_MIDDLE;
		end
	end

	always_comb begin
		scroll_ev.x = req.move_x_byte;
		scroll_ev.y = req.move_y_byte;
		scroll_ev.button = req.wheel_byte[7] ? BTN_SCROLL_DOWN : BTN_SCROLL_UP;
		scroll_ev.state = ST_MOVE;
		second_ev.x = req.move_x_byte;
		second_ev.y = req.move_y_byte;
		if (changed != 3'b000) begin
			has_second = 1'b1;
			second_ev.button = btn_code;
			second_ev.state = ((buttons & mask) != 3'b000) ? ST_DOWN : ST_UP;
		end else begin
			has_second = (req.move_x_byte != 8'h00) || (req.move_y_byte != 8'h00);
			second_ev.button = BTN_NONE;
			second_ev.state = ST_MOVE;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wdata = second_q;
		if (state_q == S_PUSH2) begin
			mem_we = 1'b1;
		end else if (accept && !is_read && !discard) begin
			mem_we = has_scroll || has_second;
			mem_wdata = has_scroll ? scroll_ev : second_ev;
		end
	end

	assign wr_next = ring_next(wr_idx_q);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_idx_q] <= mem_wdata;
		end
		if (accept && is_read) begin
			rd_data_q <= mem[rd_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !is_read) begin
			second_q <= second_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			last_buttons_q <= 3'b000;
			wr_idx_q <= '0;
			rd_idx_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (mem_we) begin
				wr_idx_q <= wr_next;
				if (wr_next == rd_idx_q) begin
					rd_idx_q <= ring_next(rd_idx_q);
				end
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (is_read) begin
							if (rd_idx_q != wr_idx_q) begin
								state_q <= S_READ;
							end
						end else if (!discard) begin
							last_buttons_q <= buttons;
							if (has_scroll && has_second) begin
								state_q <= S_PUSH2;
							end
						end
					end
				end
				S_PUSH2: begin
					state_q <= S_IDLE;
				end
				S_READ: begin
					rd_idx_q <= ring_next(rd_idx_q);
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_READ) begin
			rsp_q <= rd_data_q;
			rsp_event_valid_q <= 1'b1;
		end else if (accept && is_read) begin
			rsp_q <= '0;
			rsp_event_valid_q <= 1'b0;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.event_valid = rsp_event_valid_q;
	assign rsp.event_x = $signed(rsp_q.x);
	assign rsp.event_y = $signed(rsp_q.y);
	assign rsp.event_button = rsp_q.button;
	assign rsp.event_state = rsp_q.state;

endmodule

### rtl/hmreq_checker.sv
module hmreq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       req_mode,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_event_valid,
	input logic [7:0] rsp_event_x,
	input logic [7:0] rsp_event_y,
	input logic [2:0] rsp_event_button,
	input logic [1:0] rsp_event_state
);
	import hmreq_pkg::*;

	logic read_acc;

	assign read_acc = req_valid && req_ready && (req_mode == MODE_READ);

	a_rsp_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> ($past(read_acc) || $past(read_acc, 2)))
		else $error("Response transaction without a preceding read transaction.");

	a_empty_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_event_valid) |->
		(rsp_event_x == 8'h00 && rsp_event_y == 8'h00 &&
		 rsp_event_button == BTN_NONE && rsp_event_state == ST_MOVE))
		else $error("Empty response carries nonzero event fields.");

	a_event_code_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp_event_valid) |->
		(((rsp_event_state == ST_DOWN || rsp_event_state == ST_UP) &&
		  (rsp_event_button == BTN_LEFT || rsp_event_button == BTN_RIGHT ||
		   rsp_event_button == BTN_MIDDLE)) ||
		 ((rsp_event_state == ST_MOVE) &&
		  (rsp_event_button == BTN_NONE || rsp_event_button == BTN_SCROLL_UP ||
		   rsp_event_button == BTN_SCROLL_DOWN))))
		else $error("Popped event has an inconsistent button and state.");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
		(rsp_valid && $stable(rsp_event_valid) && $stable(rsp_event_x) &&
		 $stable(rsp_event_y) && $stable(rsp_event_button) && $stable(rsp_event_state)))
		else $error("Stalled response transaction changed.");

endmodule

bind hid_mouse_report_event_queue hmreq_checker u_hmreq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.req_mode         (req.mode),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_event_valid  (rsp.event_valid),
	.rsp_event_x      (rsp.event_x),
	.rsp_event_y      (rsp.event_y),
	.rsp_event_button (rsp.event_button),
	.rsp_event_state  (rsp.event_state)
);
